### rtl/core/mwr_pkg.sv
// Shared types, constants and the square-root step for the moving-window RMS block.
// No dependencies; the channel interfaces and the top level take names from here.
package mwr_pkg;

	localparam int WINDOW   = 400;
	localparam int PTR_W    = $clog2(WINDOW);
	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 9;
	localparam int SUM_W    = 25;
	localparam int SQ_W     = 40;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int WSQ_W    = 49;
	localparam int SUM2_W   = 2 * SUM_W;
	localparam int RAD_W    = 48;
	localparam int ROOT1_W  = SQ_W / 2;
	localparam int ROOT2_W  = RAD_W / 2;

	// floor(y / 20) = (y * RECIP20) >> SH20 for y < 2**22
	localparam int RECIP20_W = 22;
	localparam logic [RECIP20_W-1:0] RECIP20 = 22'd3355444;
	localparam int SH20 = 26;
	// floor(y / 400) = (y * RECIP400) >> SH400 for y < 2**25
	localparam int RECIP400_W = 25;
	localparam logic [RECIP400_W-1:0] RECIP400 = 25'd21474837;
	localparam int SH400 = 33;

	typedef logic [RAD_W-1:0] rad_t;

	typedef struct packed {
		rad_t x;
		rad_t res;
	} root_t;

	// One digit of the bitwise integer square root
	function automatic root_t root_step(rad_t x, rad_t res, rad_t b);
		root_t r;
		rad_t  trial;
		trial = res + b;
		if (x >= trial) begin
			r.x   = x - trial;
			r.res = (res >> 1) + b;
		end else begin
			r.x   = x;
			r.res = res >> 1;
		end
		return r;
	endfunction

endpackage

### rtl/core/mwr_in_if.sv
// Input channel of the moving-window RMS block: valid/ready plus one request.
// Depends on mwr_pkg for field widths.
interface mwr_in_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [mwr_pkg::SAMPLE_W-1:0] sample;
	logic        [mwr_pkg::DELAY_W-1:0]  delay_samples;

	modport source(output valid, op, sample, delay_samples, input ready);
	modport sink(input valid, op, sample, delay_samples, output ready);
endinterface

### rtl/core/mwr_out_if.sv
// Output channel of the moving-window RMS block: valid/ready plus one result.
// Depends on mwr_pkg for field widths.
interface mwr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [mwr_pkg::SAMPLE_W-1:0] mean;
	logic        [mwr_pkg::SAMPLE_W-1:0] rms;
	logic        [mwr_pkg::SAMPLE_W-1:0] ac_rms;
	logic signed [mwr_pkg::SAMPLE_W-1:0] delayed_sample;

	modport source(output valid, mean, rms, ac_rms, delayed_sample, input ready);
	modport sink(input valid, mean, rms, ac_rms, delayed_sample, output ready);
endinterface

### rtl/core/moving_window_rms_top.sv
// Moving-window mean / RMS / AC RMS over a 400-entry sample window.
// A request passes read, update, prep, two root phases and scaling, then waits for a free output register.
// One transaction at a time: input ready stays low until that result is registered; the pace is set
// by two 24-digit square roots on one shared root unit working two digits per cycle.
// Reset: a sweep over all 400 entries zeroes the window store; input ready stays low until done.
// Depends on mwr_pkg, mwr_in_if and mwr_out_if.
module moving_window_rms_top (
	input  logic             clk,
	input  logic             arst_n,
	mwr_in_if.sink           samples,
	mwr_out_if.source        results
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_UPD   = 4'd3;
	localparam logic [3:0] S_PREP  = 4'd4;
	localparam logic [3:0] S_ROOT1 = 4'd5;
	localparam logic [3:0] S_ROOT2 = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	localparam int W_EXT = mwr_pkg::PTR_W + 1;
	localparam mwr_pkg::rad_t ROOT_TOP = mwr_pkg::rad_t'(1) << (mwr_pkg::RAD_W - 2);
	localparam mwr_pkg::rad_t ROOT_LAST = mwr_pkg::rad_t'(4);

	logic [3:0] state_q;

	// window store
	logic signed [mwr_pkg::SAMPLE_W-1:0] win_mem [mwr_pkg::WINDOW];
	logic                                mem_we;
	logic        [mwr_pkg::PTR_W-1:0]    mem_waddr;
	logic signed [mwr_pkg::SAMPLE_W-1:0] mem_wdata;
	logic                                mem_re;
	logic        [mwr_pkg::PTR_W-1:0]    mem_raddr;
	logic signed [mwr_pkg::SAMPLE_W-1:0] rd_q;

	logic        [mwr_pkg::PTR_W-1:0]    wp_q;
	logic signed [mwr_pkg::SUM_W-1:0]    sum_q;
	logic        [mwr_pkg::SQ_W-1:0]     sumsq_q;

	logic                                op_q;
	logic signed [mwr_pkg::SAMPLE_W-1:0] samp_q;
	logic        [mwr_pkg::PROD_W-1:0]   oldsq_q;
	logic        [mwr_pkg::PROD_W-1:0]   newsq_q;
	logic signed [mwr_pkg::SAMPLE_W-1:0] dly_q;
	logic        [mwr_pkg::SUM_W-1:0]    abs_q;
	logic                                neg_q;
	logic        [mwr_pkg::SUM2_W-1:0]   sum2_q;
	logic        [mwr_pkg::WSQ_W-1:0]    wsq_q;
	logic signed [mwr_pkg::SAMPLE_W-1:0] mean_q;
	logic        [mwr_pkg::SAMPLE_W-1:0] rms_q;
	logic        [mwr_pkg::SAMPLE_W-1:0] ac_q;
	mwr_pkg::rad_t                       n_q;

	// shared root unit
	mwr_pkg::rad_t                       x_q;
	mwr_pkg::rad_t                       res_q;
	mwr_pkg::rad_t                       bit_q;
	mwr_pkg::root_t                      st1;
	mwr_pkg::root_t                      st2;
	logic        [mwr_pkg::ROOT1_W-1:0]  root1_q;
	logic        [mwr_pkg::ROOT2_W-1:0]  root2_q;

	logic                                out_valid_q;
	logic signed [mwr_pkg::SAMPLE_W-1:0] out_mean_q;
	logic        [mwr_pkg::SAMPLE_W-1:0] out_rms_q;
	logic        [mwr_pkg::SAMPLE_W-1:0] out_ac_q;
	logic signed [mwr_pkg::SAMPLE_W-1:0] out_dly_q;

	logic                                accept;
	logic                                out_free;
	logic        [mwr_pkg::DELAY_W-1:0]  d_sat;
	logic        [W_EXT-1:0]             back_idx;
	logic signed [mwr_pkg::SUM_W-1:0]    sum_abs_src;
	logic        [mwr_pkg::SUM2_W-1:0]   mean_prod;
	logic        [mwr_pkg::SAMPLE_W:0]   mean_mag;
	logic        [mwr_pkg::SUM2_W-1:0]   var_diff;
	logic        [mwr_pkg::ROOT1_W+mwr_pkg::RECIP20_W-1:0]  rms_prod;
	logic        [mwr_pkg::ROOT2_W+mwr_pkg::RECIP400_W-1:0] ac_prod;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;

	// read address for a delayed read: (wp + WINDOW - d) mod WINDOW
	always_comb begin
		d_sat = (samples.delay_samples >= mwr_pkg::DELAY_W'(mwr_pkg::WINDOW))
			? mwr_pkg::DELAY_W'(mwr_pkg::WINDOW - 1) : samples.delay_samples;
		back_idx = W_EXT'(wp_q) + W_EXT'(mwr_pkg::WINDOW) - W_EXT'(d_sat);
		if (back_idx >= W_EXT'(mwr_pkg::WINDOW)) begin
			back_idx = back_idx - W_EXT'(mwr_pkg::WINDOW);
		end
	end

	always_comb begin
		mem_re    = accept;
		mem_raddr = samples.op ? back_idx[mwr_pkg::PTR_W-1:0] : wp_q;
		mem_we    = (state_q == S_CLEAR) || (state_q == S_READ && !op_q);
		mem_waddr = wp_q;
		mem_wdata = (state_q == S_CLEAR) ? '0 : samp_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= win_mem[mem_raddr];
		end
	end

	// two root digits per cycle
	always_comb begin
		st1 = mwr_pkg::root_step(x_q, res_q, bit_q);
		st2 = mwr_pkg::root_step(st1.x, st1.res, bit_q >> 2);
	end

	assign sum_abs_src = sum_q[mwr_pkg::SUM_W-1] ? -sum_q : sum_q;
	assign mean_prod   = mwr_pkg::SUM2_W'(abs_q) * mwr_pkg::SUM2_W'(mwr_pkg::RECIP400);
	assign mean_mag    = mean_prod[mwr_pkg::SUM2_W-1:mwr_pkg::SH400];
	assign var_diff    = mwr_pkg::SUM2_W'(wsq_q) - sum2_q;
	assign rms_prod    = (mwr_pkg::ROOT1_W + mwr_pkg::RECIP20_W)'(root1_q)
		* (mwr_pkg::ROOT1_W + mwr_pkg::RECIP20_W)'(mwr_pkg::RECIP20);
	assign ac_prod     = (mwr_pkg::ROOT2_W + mwr_pkg::RECIP400_W)'(root2_q)
		* (mwr_pkg::ROOT2_W + mwr_pkg::RECIP400_W)'(mwr_pkg::RECIP400);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			wp_q    <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (wp_q == mwr_pkg::PTR_W'(mwr_pkg::WINDOW - 1)) begin
						wp_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						wp_q <= wp_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (!op_q) begin
						sum_q <= sum_q - mwr_pkg::SUM_W'(rd_q) + mwr_pkg::SUM_W'(samp_q);
						wp_q  <= (wp_q == mwr_pkg::PTR_W'(mwr_pkg::WINDOW - 1))
							? '0 : wp_q + 1'b1;
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (!op_q) begin
						sumsq_q <= sumsq_q - mwr_pkg::SQ_W'(oldsq_q) + mwr_pkg::SQ_W'(newsq_q);
					end
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_ROOT1;
				end
				S_ROOT1: begin
					if (bit_q == ROOT_LAST) begin
						state_q <= S_ROOT2;
					end
				end
				S_ROOT2: begin
					if (bit_q == ROOT_LAST) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= samples.op;
			samp_q <= samples.sample;
		end
		if (state_q == S_READ) begin
			oldsq_q <= mwr_pkg::PROD_W'(rd_q) * mwr_pkg::PROD_W'(rd_q);
			newsq_q <= mwr_pkg::PROD_W'(samp_q) * mwr_pkg::PROD_W'(samp_q);
			dly_q   <= op_q ? rd_q : '0;
		end
		if (state_q == S_UPD) begin
			abs_q <= sum_abs_src;
			neg_q <= sum_q[mwr_pkg::SUM_W-1];
		end
		if (state_q == S_PREP) begin
			sum2_q <= mwr_pkg::SUM2_W'(abs_q) * mwr_pkg::SUM2_W'(abs_q);
			wsq_q  <= mwr_pkg::WSQ_W'(sumsq_q) * mwr_pkg::WSQ_W'(mwr_pkg::WINDOW);
			mean_q <= mwr_pkg::SAMPLE_W'(neg_q ? (~mean_mag + 1'b1) : mean_mag);
			x_q    <= mwr_pkg::RAD_W'(sumsq_q);
			res_q  <= '0;
			bit_q  <= ROOT_TOP;
		end
		if (state_q == S_ROOT1) begin
			// clamp a negative variance to zero
			n_q <= (mwr_pkg::SUM2_W'(wsq_q) >= sum2_q) ? var_diff[mwr_pkg::RAD_W-1:0] : '0;
			if (bit_q == ROOT_LAST) begin
				root1_q <= st2.res[mwr_pkg::ROOT1_W-1:0];
				x_q     <= n_q;
				res_q   <= '0;
				bit_q   <= ROOT_TOP;
			end else begin
				x_q   <= st2.x;
				res_q <= st2.res;
				bit_q <= bit_q >> 4;
			end
		end
		if (state_q == S_ROOT2) begin
			if (bit_q == ROOT_LAST) begin
				root2_q <= st2.res[mwr_pkg::ROOT2_W-1:0];
			end
			x_q   <= st2.x;
			res_q <= st2.res;
			bit_q <= bit_q >> 4;
		end
		if (state_q == S_DIV) begin
			rms_q <= rms_prod[mwr_pkg::SH20 +: mwr_pkg::SAMPLE_W];
			ac_q  <= ac_prod[mwr_pkg::SH400 +: mwr_pkg::SAMPLE_W];
		end
		if (state_q == S_DONE && out_free) begin
			out_mean_q <= mean_q;
			out_rms_q  <= rms_q;
			out_ac_q   <= ac_q;
			out_dly_q  <= dly_q;
		end
	end

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.mean           = out_mean_q;
	assign results.rms            = out_rms_q;
	assign results.ac_rms         = out_ac_q;
	assign results.delayed_sample = out_dly_q;

`ifndef SYNTHESIS
	wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q < mwr_pkg::PTR_W'(mwr_pkg::WINDOW))
		else $error("write pointer left the window");

	root_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> bit_q == '0)
		else $error("root unit not finished before scaling");

	ac_below_rms: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.ac_rms <= results.rms)
		else $error("AC RMS exceeds RMS");

	result_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && results.valid && !results.ready |=> state_q == S_DONE)
		else $error("pending result overwritten");
`endif

endmodule
